[rtl/stl_pkg.sv]
package stl_pkg;

	typedef enum logic [1:0] {
		OP_LOOKUP     = 2'd0,
		OP_TOUCH      = 2'd1,
		OP_CREATE     = 2'd2,
		OP_INVALIDATE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PICK,
		ST_SCAN,
		ST_HOLD
	} state_t;

	localparam logic [15:0] TIMEOUT_RESET = 16'd60;

	typedef struct packed {
		op_t         operation;
		logic [15:0] node_id;
		logic [31:0] now_seconds;
	} in_item_t;

	typedef struct packed {
		logic       found;
		logic [2:0] slot_index;
	} out_item_t;

	typedef struct packed {
		logic        active;
		logic        pick_pass;
		op_t         op;
		logic [15:0] node;
		logic [31:0] now;
		logic        hit;
	} chain_ctl_t;

endpackage

[rtl/stl_cell.sv]
module stl_cell #(
	parameter int SLOTS = 8,
	parameter int IDX = 0,
	parameter int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         timeout,
	input  logic [SW-1:0]       pick_slot,
	input  stl_pkg::chain_ctl_t ctl_in,
	input  logic [SW-1:0]       slot_in,
	input  logic [31:0]         time_in,
	output stl_pkg::chain_ctl_t ctl_out,
	output logic [SW-1:0]       slot_out,
	output logic [31:0]         time_out
);
	import stl_pkg::*;

	localparam logic [SW-1:0] MY_SLOT = SW'(IDX);

	logic        valid_q;
	logic [15:0] node_q;
	logic [31:0] last_q;
	chain_ctl_t  ctl_q;
	logic [SW-1:0] slot_q;
	logic [31:0] time_q;

	logic        valid_d;
	logic        node_we;
	logic        last_we;
	chain_ctl_t  ctl_d;
	logic [SW-1:0] slot_d;
	logic [31:0] time_d;
	logic [32:0] limit;
	logic        expired;

	assign limit   = {1'b0, last_q} + {17'b0, timeout};
	assign expired = {1'b0, ctl_in.now} > limit;

	always_comb begin
		ctl_d   = ctl_in;
		slot_d  = slot_in;
		time_d  = time_in;
		valid_d = valid_q;
		node_we = 1'b0;
		last_we = 1'b0;
		if (ctl_in.active) begin
			if (ctl_in.pick_pass) begin
				if (!ctl_in.hit) begin
					if (!valid_q) begin
						ctl_d.hit = 1'b1;
						slot_d    = MY_SLOT;
					end else if (IDX == 0 || last_q < time_in) begin
						slot_d = MY_SLOT;
						time_d = last_q;
					end
				end
			end else if (ctl_in.op == OP_CREATE && pick_slot == MY_SLOT) begin
				valid_d = 1'b1;
				node_we = 1'b1;
				last_we = 1'b1;
				if (!ctl_in.hit) begin
					ctl_d.hit = 1'b1;
					slot_d    = MY_SLOT;
				end
			end else if (!ctl_in.hit && valid_q) begin
				if (expired) begin
					valid_d = 1'b0;
				end else if (node_q == ctl_in.node) begin
					ctl_d.hit = 1'b1;
					slot_d    = MY_SLOT;
					case (ctl_in.op)
						OP_TOUCH, OP_CREATE: last_we = 1'b1;
						OP_INVALIDATE:       valid_d = 1'b0;
						default:             ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ctl_q   <= '0;
		end else begin
			valid_q <= valid_d;
			ctl_q   <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_q <= ctl_in.node;
		end
		if (last_we) begin
			last_q <= ctl_in.now;
		end
		slot_q <= slot_d;
		time_q <= time_d;
	end

	assign ctl_out  = ctl_q;
	assign slot_out = slot_q;
	assign time_out = time_q;

endmodule

[rtl/session_table_timeout_lru.sv]
// Lookup, touch and invalidate walk the cell chain once. Create first walks
// the cell chain to pick a slot, then walks it again to write and touch.
// Each walk is a wave that steps one cell per cycle down the chain. A new
// item is accepted only once the last result has gone into the output register.
// Reset clears all valid marks and sets the timeout to 60; stored node ids
// and times are not cleared.
module session_table_timeout_lru #(
	parameter int SLOTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  stl_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output stl_pkg::out_item_t out_item
);
	import stl_pkg::*;

	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	state_t      state_q;
	state_t      state_d;
	logic [15:0] timeout_q;
	in_item_t    item_q;
	logic        launch_q;
	logic [SW-1:0] pick_q;
	out_item_t   pend_q;
	out_item_t   out_q;
	logic        out_valid_q;

	logic        launch_d;
	logic        load_item;
	logic        load_pick;
	logic        load_out;
	logic        load_pend;
	out_item_t   result;

	chain_ctl_t    ctl_w  [0:SLOTS];
	logic [SW-1:0] slot_w [0:SLOTS];
	logic [31:0]   time_w [0:SLOTS];

	assign ctl_w[0].active    = launch_q;
	assign ctl_w[0].pick_pass = (state_q == ST_PICK);
	assign ctl_w[0].op        = item_q.operation;
	assign ctl_w[0].node      = item_q.node_id;
	assign ctl_w[0].now       = item_q.now_seconds;
	assign ctl_w[0].hit       = 1'b0;
	assign slot_w[0]          = '0;
	assign time_w[0]          = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		stl_cell #(
			.SLOTS(SLOTS),
			.IDX  (i),
			.SW   (SW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.timeout  (timeout_q),
			.pick_slot(pick_q),
			.ctl_in   (ctl_w[i]),
			.slot_in  (slot_w[i]),
			.time_in  (time_w[i]),
			.ctl_out  (ctl_w[i+1]),
			.slot_out (slot_w[i+1]),
			.time_out (time_w[i+1])
		);
	end

	always_comb begin
		if (item_q.operation == OP_CREATE) begin
			result.found      = 1'b1;
			result.slot_index = 3'(pick_q);
		end else begin
			result.found      = ctl_w[SLOTS].hit;
			result.slot_index = ctl_w[SLOTS].hit ? 3'(slot_w[SLOTS]) : 3'd0;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		launch_d  = 1'b0;
		load_item = 1'b0;
		load_pick = 1'b0;
		load_out  = 1'b0;
		load_pend = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					load_item = 1'b1;
					launch_d  = 1'b1;
					state_d   = (in_item.operation == OP_CREATE) ? ST_PICK : ST_SCAN;
				end
			end
			ST_PICK: begin
				if (ctl_w[SLOTS].active) begin
					load_pick = 1'b1;
					launch_d  = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (ctl_w[SLOTS].active) begin
					if (!out_valid_q || out_ready) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						load_pend = 1'b1;
						state_d   = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
			timeout_q   <= TIMEOUT_RESET;
		end else begin
			state_q  <= state_d;
			launch_q <= launch_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			item_q <= in_item;
		end
		if (load_pick) begin
			pick_q <= slot_w[SLOTS];
		end
		if (load_pend) begin
			pend_q <= result;
		end
		if (load_out) begin
			out_q <= (state_q == ST_HOLD) ? pend_q : result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
